// ----- src/psfp_pkg.sv -----
// Shared types and constants for the particle sensor frame parser.
// No dependencies; imported by particle_sensor_frame_parser.
`timescale 1ns / 1ps

package psfp_pkg;

	// Frame framing bytes and limits
	localparam logic [7:0] HeadByte = 8'h40;
	localparam logic [7:0] CmdByte  = 8'h04;
	localparam logic [7:0] MaxBody  = 8'd30;
	localparam logic [4:0] LenShort = 5'd5;
	localparam logic [4:0] LenLong  = 5'd13;
	localparam int unsigned ValueBytes = 8;

	// Request kinds
	localparam logic ActByte    = 1'b0;
	localparam logic ActTimeout = 1'b1;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_HEAD_TIMEOUT = 3'd1,
		ST_BAD_HEAD     = 3'd2,
		ST_BODY_TIMEOUT = 3'd3,
		ST_BAD_CMD      = 3'd4,
		ST_SUM_TIMEOUT  = 3'd5,
		ST_SUM_BAD      = 3'd6,
		ST_BAD_LEN      = 3'd7
	} status_t;

	// Parser phase, one-hot
	typedef enum logic [3:0] {
		PH_HEAD = 4'b0001,
		PH_LEN  = 4'b0010,
		PH_BODY = 4'b0100,
		PH_SUM  = 4'b1000
	} phase_t;

	// One received request
	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
	} rx_item_t;

	// One frame result
	typedef struct packed {
		status_t     status;
		logic        measurement_valid;
		logic        four_values;
		logic [15:0] pm1_value;
		logic [15:0] pm25_value;
		logic [15:0] pm4_value;
		logic [15:0] pm10_value;
	} res_item_t;

endpackage

// ----- src/particle_sensor_frame_parser.sv -----
// Particle sensor reply frame parser: byte-wise frame check and PM value decode.
// Depends on psfp_pkg for payload structs, phase and status codes.
`timescale 1ns / 1ps

//  channel | signals                          | payload
//  --------+----------------------------------+---------------------------------
//  rx      | rx_valid, rx_ready, rx_item      | action, rx_byte
//  res     | res_valid, res_ready, res_item   | status, flags, four PM values
//
// One request per cycle unless a held result stalls it. A request is held in the
// input register and then folded into the frame state; its result, if any,
// lands in the result register on that same edge. Reset returns to awaiting the
// head byte with both registers empty. A held result stalls only requests that
// would produce another result; plain body bytes keep flowing.

module particle_sensor_frame_parser
	import psfp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      rx_valid,
	output logic      rx_ready,
	input  rx_item_t  rx_item,
	output logic      res_valid,
	input  logic      res_ready,
	output res_item_t res_item
);

	// Input register
	logic     rx_valid_s1;
	rx_item_t rx_item_s1;

	// Frame state
	phase_t     phase_q;
	logic [4:0] body_length_q;
	logic [4:0] body_index_q;
	logic [7:0] running_sum_q;
	logic       command_matched_q;
	logic [7:0] value_bytes_q [ValueBytes];

	// Result register
	logic      res_valid_q;
	res_item_t res_item_q;

	// Next-state values
	phase_t     phase_d;
	logic [4:0] body_length_d;
	logic [4:0] body_index_d;
	logic [7:0] running_sum_d;
	logic       command_matched_d;
	logic       vb_we;
	logic [2:0] vb_idx;
	logic       emit;
	res_item_t  res_d;

	logic       out_free;
	logic       advance;
	logic [7:0] b;
	logic [7:0] sum_plus;
	logic [4:0] index_inc;
	logic       cmd_now;

	assign b         = rx_item_s1.rx_byte;
	assign sum_plus  = running_sum_q + b;
	assign index_inc = body_index_q + 5'd1;
	assign cmd_now   = (body_index_q == 5'd0) ? (b == CmdByte) : command_matched_q;

	// Fold the held request into the frame state
	always_comb begin
		phase_d           = phase_q;
		body_length_d     = body_length_q;
		body_index_d      = body_index_q;
		running_sum_d     = running_sum_q;
		command_matched_d = command_matched_q;
		vb_we             = 1'b0;
		vb_idx            = body_index_q[2:0] - 3'd1;
		emit              = 1'b0;
		res_d             = '0;
		res_d.status      = ST_OK;

		if (rx_item_s1.action == ActTimeout) begin
			emit = 1'b1;
			unique case (phase_q)
				PH_BODY: res_d.status = ST_BODY_TIMEOUT;
				PH_SUM:  res_d.status = ST_SUM_TIMEOUT;
				default: res_d.status = ST_HEAD_TIMEOUT;
			endcase
		end else begin
			unique case (phase_q)
				PH_HEAD: begin
					if (b != HeadByte) begin
						emit         = 1'b1;
						res_d.status = ST_BAD_HEAD;
					end else begin
						running_sum_d = HeadByte;
						phase_d       = PH_LEN;
					end
				end
				PH_LEN: begin
					if (b == 8'd0 || b > MaxBody) begin
						emit         = 1'b1;
						res_d.status = ST_BAD_HEAD;
					end else begin
						body_length_d = b[4:0];
						body_index_d  = 5'd0;
						running_sum_d = sum_plus;
						phase_d       = PH_BODY;
					end
				end
				PH_BODY: begin
					command_matched_d = cmd_now;
					vb_we = (body_index_q != 5'd0) && (body_index_q <= 5'd8);
					running_sum_d = sum_plus;
					body_index_d  = index_inc;
					if (index_inc == body_length_q) begin
						if (!cmd_now) begin
							emit         = 1'b1;
							res_d.status = ST_BAD_CMD;
						end else begin
							phase_d = PH_SUM;
						end
					end
				end
				default: begin
					// Checksum good when head + length + body + byte wraps to zero
					emit = 1'b1;
					if (sum_plus != 8'd0) begin
						res_d.status = ST_SUM_BAD;
					end else if (body_length_q == LenShort) begin
						res_d.measurement_valid = 1'b1;
						res_d.pm25_value = {value_bytes_q[0], value_bytes_q[1]};
						res_d.pm10_value = {value_bytes_q[2], value_bytes_q[3]};
					end else if (body_length_q == LenLong) begin
						res_d.measurement_valid = 1'b1;
						res_d.four_values = 1'b1;
						res_d.pm1_value  = {value_bytes_q[0], value_bytes_q[1]};
						res_d.pm25_value = {value_bytes_q[2], value_bytes_q[3]};
						res_d.pm4_value  = {value_bytes_q[4], value_bytes_q[5]};
						res_d.pm10_value = {value_bytes_q[6], value_bytes_q[7]};
					end else begin
						res_d.status = ST_BAD_LEN;
					end
				end
			endcase
		end

		// Any result ends the frame: drop back to awaiting head
		if (emit) begin
			phase_d           = PH_HEAD;
			body_length_d     = 5'd0;
			body_index_d      = 5'd0;
			running_sum_d     = 8'd0;
			command_matched_d = 1'b0;
		end
	end

	// Handshake: stall only when a result is due and the slot is full
	assign out_free  = !res_valid_q || res_ready;
	assign advance   = rx_valid_s1 && (!emit || out_free);
	assign rx_ready  = !rx_valid_s1 || advance;
	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			rx_valid_s1 <= rx_valid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			rx_item_s1 <= rx_item;
		end
	end

	// Frame state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= PH_HEAD;
			body_length_q     <= 5'd0;
			body_index_q      <= 5'd0;
			running_sum_q     <= 8'd0;
			command_matched_q <= 1'b0;
		end else if (advance) begin
			phase_q           <= phase_d;
			body_length_q     <= body_length_d;
			body_index_q      <= body_index_d;
			running_sum_q     <= running_sum_d;
			command_matched_q <= command_matched_d;
		end
	end

	// Keep body bytes one through eight
	always_ff @(posedge clk) begin
		if (advance && vb_we) begin
			value_bytes_q[vb_idx] <= b;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_item_q <= res_d;
		end
	end

endmodule
